>>> src/lfb_pkg.sv
// Shared types, constants and fixed-point helpers for the D3Q7 flux boundary block.
package lfb_pkg;

    localparam int VW   = 32;          // value width
    localparam int FB   = 16;          // fraction bits
    localparam int QW   = VW + FB;     // dividend width of a quotient
    localparam int MW   = QW + 1;      // magnitude width before packing
    localparam int PW   = 2 * VW;      // full product width
    localparam int RW   = VW + 1;      // partial remainder width
    localparam int CW   = 3;           // register index width
    localparam int CNTW = $clog2(QW);
    localparam int ZW   = 5;           // valence width

    typedef logic signed [VW-1:0] val_t;
    typedef logic [1:0] mode_t;

    localparam val_t VMAX = {1'b0, {(VW-1){1'b1}}};
    localparam val_t VMIN = {1'b1, {(VW-1){1'b0}}};
    localparam val_t ONE  = val_t'(1 << FB);
    localparam val_t HALF = val_t'(1 << (FB - 1));

    localparam mode_t MODE_DIFF = 2'd1;
    localparam mode_t MODE_ELEC = 2'd2;

    typedef enum logic [CW-1:0] {
        REG_MODE,
        REG_SIDE,
        REG_TAU,
        REG_FLUX,
        REG_DIFF,
        REG_VAL,
        REG_VT
    } reg_idx_t;

    typedef enum logic [2:0] {
        CS_IDLE,
        CS_LOAD_H,
        CS_RUN_H,
        CS_LOAD_T,
        CS_RUN_T
    } cfg_state_t;

    typedef struct packed {
        logic           neg;
        logic [PW-1:0]  mag;
    } prod_t;

    typedef struct packed {
        mode_t  mode;
        logic   side;
        val_t   flux;
        val_t   h;
        val_t   a;
        val_t   t;
        logic   hfault;
        logic   tfault;
    } cfg_t;

    typedef struct packed {
        val_t   num;
        logic   fault;
        logic   mode1;
        val_t   d2;
    } side_t;

    typedef struct packed {
        logic [RW-1:0]  r;
        logic [QW-1:0]  q;
        logic [QW-1:0]  x;
        logic [VW-1:0]  dd;
    } div_t;

    function automatic logic [VW-1:0] magn(val_t v);
        return v[VW-1] ? VW'(-v) : VW'(v);
    endfunction

    function automatic val_t pack(logic neg, logic [MW-1:0] m);
        if (!neg)
            return (m > {{(MW-VW){1'b0}}, VMAX}) ? VMAX : val_t'(m[VW-1:0]);
        if (m > {{(MW-VW){1'b0}}, VMIN})
            return VMIN;
        return val_t'(-m[VW-1:0]);
    endfunction

    function automatic val_t sadd(val_t a, val_t b);
        logic [VW:0] s;
        s = {a[VW-1], a} + {b[VW-1], b};
        if (s[VW] != s[VW-1])
            return s[VW] ? VMIN : VMAX;
        return val_t'(s[VW-1:0]);
    endfunction

    function automatic val_t ssub(val_t a, val_t b);
        return sadd(a, (b == VMIN) ? VMAX : val_t'(-b));
    endfunction

    function automatic prod_t pmul(val_t a, val_t b);
        prod_t p;
        p.neg = a[VW-1] ^ b[VW-1];
        p.mag = PW'(magn(a)) * PW'(magn(b));
        return p;
    endfunction

    // Round to nearest with ties away from zero, then saturate.
    function automatic val_t prnd(prod_t p);
        logic [PW:0] s;
        s = {1'b0, p.mag} + (PW+1)'(1 << (FB - 1));
        return pack(p.neg, MW'(s >> FB));
    endfunction

    function automatic div_t dinit(val_t n, logic [VW-1:0] dd);
        div_t o;
        o.r  = '0;
        o.q  = '0;
        o.x  = {magn(n), {FB{1'b0}}};
        o.dd = dd;
        return o;
    endfunction

    // One restoring long-division step: one quotient bit.
    function automatic div_t dstep(div_t s);
        div_t o;
        logic [RW-1:0] r;
        r    = {s.r[RW-2:0], s.x[QW-1]};
        o.x  = s.x << 1;
        o.q  = s.q << 1;
        o.dd = s.dd;
        if (r >= RW'(s.dd)) begin
            r      = r - RW'(s.dd);
            o.q[0] = 1'b1;
        end
        o.r = r;
        return o;
    endfunction

    function automatic val_t dfin(div_t s, logic neg);
        logic [MW-1:0] q;
        q = {1'b0, s.q} + MW'({s.r, 1'b0} >= (RW+1)'(s.dd));
        return pack(neg, q);
    endfunction

endpackage

>>> src/lfb_cfg.sv
// Configuration registers and the iterative unit deriving 0.5/tau, 1 - 0.5/tau and t.
module lfb_cfg
    import lfb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CW-1:0]   cfg_index,
    input  logic [VW-1:0]   cfg_data,
    output logic            busy,
    output cfg_t            cfg
);

    cfg_state_t          state_reg, state_next;
    mode_t               mode_reg;
    logic                side_reg;
    logic [VW-2:0]       tau_reg;
    val_t                flux_reg;
    logic [VW-2:0]       diff_reg;
    logic signed [ZW-1:0] val_reg;
    logic [VW-2:0]       vt_reg;
    val_t                h_reg;
    val_t                a_reg;
    val_t                t_reg;
    logic                hfault_reg;
    logic                tfault_reg;
    logic [CNTW-1:0]     cnt_reg;
    div_t                dv_reg;
    logic                neg_reg;

    logic                wr;
    logic                load_h;
    logic                load_t;
    logic                run;
    logic                last;
    logic [ZW-1:0]       zmag;
    val_t                dnum;
    div_t                dv_step;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid;
    assign zmag      = val_reg[ZW-1] ? ZW'(-val_reg) : ZW'(val_reg);
    assign dnum      = pack(val_reg[ZW-1], MW'(diff_reg) * MW'(zmag));
    assign dv_step   = dstep(dv_reg);

    always_comb
    begin
        state_next = state_reg;
        if (wr)
        begin
            state_next = CS_LOAD_H;
        end
        else
        begin
            case (state_reg)
                CS_IDLE:   state_next = CS_IDLE;
                CS_LOAD_H: state_next = CS_RUN_H;
                CS_RUN_H:  state_next = last ? CS_LOAD_T : CS_RUN_H;
                CS_LOAD_T: state_next = CS_RUN_T;
                CS_RUN_T:  state_next = last ? CS_IDLE : CS_RUN_T;
                default:   state_next = CS_IDLE;
            endcase
        end
    end

    always_comb
    begin
        busy   = 1'b1;
        load_h = 1'b0;
        load_t = 1'b0;
        run    = 1'b0;
        case (state_reg)
            CS_IDLE:   busy   = 1'b0;
            CS_LOAD_H: load_h = 1'b1;
            CS_RUN_H:  run    = 1'b1;
            CS_LOAD_T: load_t = 1'b1;
            CS_RUN_T:  run    = 1'b1;
            default:   busy   = 1'b1;
        endcase
    end

    assign last = run && (cnt_reg == CNTW'(QW - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= CS_IDLE;
            mode_reg   <= '0;
            side_reg   <= 1'b0;
            tau_reg    <= (VW-1)'(ONE);
            flux_reg   <= '0;
            diff_reg   <= '0;
            val_reg    <= ZW'(1);
            vt_reg     <= (VW-1)'(ONE);
            h_reg      <= HALF;
            a_reg      <= HALF;
            t_reg      <= '0;
            hfault_reg <= 1'b0;
            tfault_reg <= 1'b0;
            cnt_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr)
            begin
                case (cfg_index)
                    REG_MODE: mode_reg <= cfg_data[1:0];
                    REG_SIDE: side_reg <= cfg_data[0];
                    REG_TAU:  tau_reg  <= cfg_data[VW-2:0];
                    REG_FLUX: flux_reg <= val_t'(cfg_data);
                    REG_DIFF: diff_reg <= cfg_data[VW-2:0];
                    REG_VAL:  val_reg  <= cfg_data[ZW-1:0];
                    REG_VT:   vt_reg   <= cfg_data[VW-2:0];
                    default:  ;
                endcase
            end
            if (load_h || load_t)
                cnt_reg <= '0;
            else if (run)
                cnt_reg <= cnt_reg + CNTW'(1);
            if (load_t)
                a_reg <= ssub(ONE, h_reg);
            if (last && state_reg == CS_RUN_H)
            begin
                hfault_reg <= (tau_reg == '0);
                h_reg      <= (tau_reg == '0) ? VMAX : dfin(dv_step, neg_reg);
            end
            if (last && state_reg == CS_RUN_T)
            begin
                tfault_reg <= (vt_reg == '0);
                t_reg      <= dfin(dv_step, neg_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_h)
        begin
            dv_reg  <= dinit(HALF, {1'b0, tau_reg});
            neg_reg <= 1'b0;
        end
        else if (load_t)
        begin
            dv_reg  <= dinit(dnum, {1'b0, vt_reg});
            neg_reg <= dnum[VW-1];
        end
        else if (run)
        begin
            dv_reg <= dv_step;
        end
    end

    assign cfg.mode   = mode_reg;
    assign cfg.side   = side_reg;
    assign cfg.flux   = flux_reg;
    assign cfg.h      = h_reg;
    assign cfg.a      = a_reg;
    assign cfg.t      = t_reg;
    assign cfg.hfault = hfault_reg;
    assign cfg.tfault = tfault_reg;

endmodule

>>> src/lfb_front.sv
// Front pipeline: node sum, products and the numerator and divisor of the boundary equation.
module lfb_front
    import lfb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            in_valid,
    input  logic [8*VW-1:0] in_data,
    input  cfg_t            cfg,
    output logic            out_valid,
    output val_t            out_n,
    output val_t            out_d,
    output side_t           out_side
);

    logic  v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic  mode1, mode2;
    val_t  f0, f1, f2, f3, f4, kin, uzin, ezin;

    val_t  s3_1_reg, f3_1_reg, f4_1_reg, k_1_reg, uz_1_reg;
    prod_t puzh_1_reg, ptez_1_reg, pak_1_reg;

    val_t  s_2_reg, w0_2_reg, m2_2_reg, ak_2_reg, k_2_reg, uz_2_reg;

    val_t  w_3_reg, s_3_reg, ak_3_reg, k_3_reg, uz_3_reg;
    prod_t pus_3_reg;

    val_t  m_4_reg, w_4_reg, ak_4_reg, k_4_reg, uz_4_reg;
    prod_t pws_4_reg;

    val_t  ws_5_reg, inner_5_reg, jak_5_reg, w_5_reg, uz_5_reg;

    val_t  num_6_reg, den_6_reg, d2_6_reg;
    prod_t pai_6_reg;

    val_t  num_7_reg, den_7_reg, d2_7_reg;

    assign mode1 = (cfg.mode == MODE_DIFF);
    assign mode2 = (cfg.mode == MODE_ELEC);

    assign f0   = val_t'(in_data[0*VW +: VW]);
    assign f1   = val_t'(in_data[1*VW +: VW]);
    assign f2   = val_t'(in_data[2*VW +: VW]);
    assign f3   = val_t'(in_data[3*VW +: VW]);
    assign f4   = val_t'(in_data[4*VW +: VW]);
    assign kin  = val_t'(in_data[5*VW +: VW]);
    assign uzin = val_t'(in_data[6*VW +: VW]);
    assign ezin = val_t'(in_data[7*VW +: VW]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // The saturating sum is order dependent, so it runs left to right.
            s3_1_reg   <= sadd(sadd(f0, f1), f2);
            f3_1_reg   <= f3;
            f4_1_reg   <= f4;
            k_1_reg    <= kin;
            uz_1_reg   <= uzin;
            puzh_1_reg <= pmul(uzin, cfg.h);
            ptez_1_reg <= pmul(cfg.t, ezin);
            pak_1_reg  <= pmul(cfg.a, kin);

            s_2_reg  <= sadd(sadd(sadd(s3_1_reg, f3_1_reg), f4_1_reg), k_1_reg);
            w0_2_reg <= prnd(puzh_1_reg);
            m2_2_reg <= prnd(ptez_1_reg);
            ak_2_reg <= prnd(pak_1_reg);
            k_2_reg  <= k_1_reg;
            uz_2_reg <= uz_1_reg;

            w_3_reg   <= mode2 ? sadd(w0_2_reg, m2_2_reg) : w0_2_reg;
            pus_3_reg <= pmul(uz_2_reg, s_2_reg);
            s_3_reg   <= s_2_reg;
            ak_3_reg  <= ak_2_reg;
            k_3_reg   <= k_2_reg;
            uz_3_reg  <= uz_2_reg;

            m_4_reg   <= prnd(pus_3_reg);
            pws_4_reg <= pmul(w_3_reg, s_3_reg);
            w_4_reg   <= w_3_reg;
            ak_4_reg  <= ak_3_reg;
            k_4_reg   <= k_3_reg;
            uz_4_reg  <= uz_3_reg;

            ws_5_reg    <= prnd(pws_4_reg);
            inner_5_reg <= cfg.side ? ssub(k_4_reg, m_4_reg) : sadd(k_4_reg, m_4_reg);
            jak_5_reg   <= sadd(cfg.flux, ak_4_reg);
            w_5_reg     <= w_4_reg;
            uz_5_reg    <= uz_4_reg;

            num_6_reg <= cfg.side ? sadd(jak_5_reg, ws_5_reg) : ssub(jak_5_reg, ws_5_reg);
            den_6_reg <= cfg.side ? ssub(cfg.a, w_5_reg) : sadd(cfg.a, w_5_reg);
            d2_6_reg  <= cfg.side ? sadd(ONE, uz_5_reg) : ssub(ONE, uz_5_reg);
            pai_6_reg <= pmul(cfg.a, inner_5_reg);

            num_7_reg <= mode1 ? sadd(cfg.flux, prnd(pai_6_reg)) : num_6_reg;
            den_7_reg <= mode1 ? cfg.a : den_6_reg;
            d2_7_reg  <= d2_6_reg;
        end
    end

    assign out_valid      = v7_reg;
    assign out_n          = num_7_reg;
    assign out_d          = den_7_reg;
    assign out_side.num   = num_7_reg;
    assign out_side.fault = cfg.hfault | (mode2 & cfg.tfault);
    assign out_side.mode1 = mode1;
    assign out_side.d2    = d2_7_reg;

endmodule

>>> src/lfb_div.sv
// Pipelined signed fixed-point divider, one quotient bit per stage, rounded and saturated.
module lfb_div
    import lfb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    en,
    input  logic    in_valid,
    input  val_t    in_n,
    input  val_t    in_d,
    input  side_t   in_side,
    output logic    out_valid,
    output val_t    out_q,
    output logic    out_zero,
    output side_t   out_side
);

    logic  v_reg    [0:QW];
    div_t  st_reg   [0:QW];
    logic  neg_reg  [0:QW];
    logic  zero_reg [0:QW];
    side_t side_reg [0:QW];

    logic  vo_reg;
    val_t  q_reg;
    logic  zo_reg;
    side_t so_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QW; k++)
                v_reg[k] <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= QW; k++)
                v_reg[k] <= v_reg[k-1];
            vo_reg <= v_reg[QW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg[0]   <= dinit(in_n, magn(in_d));
            neg_reg[0]  <= in_n[VW-1] ^ in_d[VW-1];
            zero_reg[0] <= (in_d == '0);
            side_reg[0] <= in_side;
            for (int k = 1; k <= QW; k++)
            begin
                st_reg[k]   <= dstep(st_reg[k-1]);
                neg_reg[k]  <= neg_reg[k-1];
                zero_reg[k] <= zero_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
            q_reg  <= dfin(st_reg[QW], neg_reg[QW]);
            zo_reg <= zero_reg[QW];
            so_reg <= side_reg[QW];
        end
    end

    assign out_valid = vo_reg;
    assign out_q     = q_reg;
    assign out_zero  = zo_reg;
    assign out_side  = so_reg;

endmodule

>>> src/lattice_flux_boundary_unknown.sv
// D3Q7 flux boundary top level: streams one node per cycle to one result when not held.
//
// The block accepts one boundary node per clock cycle while not busy or stalled and returns
// one result per node, in order, through the front pipeline of sums and products, two
// dividers of 50 stages each (an input stage, stages that each yield one quotient bit, and
// a rounding stage) and an output register. A stall on the result side holds the whole
// pipeline. After every configuration write s_axis_tready is low while a shared iterative
// divider derives 0.5/tau and the electromigration coefficient; every such write is taken.
module lattice_flux_boundary_unknown
    import lfb_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    // rest_dist, dist_x_pos, dist_x_neg, dist_y_pos, dist_y_neg, known_z_dist,
    // velocity_z, field_z; 32 bits each
    input  logic [8*VW-1:0] s_axis_tdata,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    // unknown_dist
    output logic [VW-1:0]   m_axis_tdata,
    // divide_fault
    output logic            m_axis_tuser,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [CW-1:0]   cfg_index,
    input  logic [VW-1:0]   cfg_data
);

    cfg_t   cfg;
    logic   busy;
    logic   en;

    logic   fv;
    val_t   fn, fd;
    side_t  fside;

    logic   v1;
    val_t   q1;
    logic   z1;
    side_t  s1, s1_fix;

    logic   v2;
    val_t   q2;
    logic   z2;
    side_t  s2;

    logic   fault;
    logic   tvalid_reg;
    val_t   tdata_reg;
    logic   tuser_reg;

    assign en            = !tvalid_reg || m_axis_tready;
    assign s_axis_tready = en && !busy;

    lfb_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .cfg       (cfg)
    );

    lfb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid && s_axis_tready),
        .in_data   (s_axis_tdata),
        .cfg       (cfg),
        .out_valid (fv),
        .out_n     (fn),
        .out_d     (fd),
        .out_side  (fside)
    );

    lfb_div u_div1 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fv),
        .in_n      (fn),
        .in_d      (fd),
        .in_side   (fside),
        .out_valid (v1),
        .out_q     (q1),
        .out_zero  (z1),
        .out_side  (s1)
    );

    // In the diffusive mode the first quotient is divided again; otherwise it passes
    // through a division by one, which is exact.
    always_comb
    begin
        s1_fix       = s1;
        s1_fix.fault = s1.fault | z1;
    end

    lfb_div u_div2 (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1),
        .in_n      (q1),
        .in_d      (s1.mode1 ? s1.d2 : ONE),
        .in_side   (s1_fix),
        .out_valid (v2),
        .out_q     (q2),
        .out_zero  (z2),
        .out_side  (s2)
    );

    assign fault = s2.fault | z2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tvalid_reg <= 1'b0;
        else if (en)
            tvalid_reg <= v2;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tuser_reg <= fault;
            tdata_reg <= fault ? (s2.num[VW-1] ? VMIN : VMAX) : q2;
        end
    end

    assign m_axis_tvalid = tvalid_reg;
    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tuser  = tuser_reg;

endmodule

>>> src/lfb_chk.sv
// Port-level checker for the flux boundary block, bound to the top level.
module lfb_chk
    import lfb_pkg::*;
(
    input logic            clk,
    input logic            rst_n,
    input logic            s_axis_tvalid,
    input logic            s_axis_tready,
    input logic [8*VW-1:0] s_axis_tdata,
    input logic            m_axis_tvalid,
    input logic            m_axis_tready,
    input logic [VW-1:0]   m_axis_tdata,
    input logic            m_axis_tuser,
    input logic            cfg_valid,
    input logic            cfg_ready,
    input logic [CW-1:0]   cfg_index,
    input logic [VW-1:0]   cfg_data
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A faulted result is always one of the two saturation values.
    a_fault_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |->
            (m_axis_tdata == VMAX) || (m_axis_tdata == VMIN))
        else $error("faulted result is not saturated");

    // Coefficients are recomputed after a write, so no node is taken next cycle.
    a_cfg_block: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !s_axis_tready)
        else $error("node accepted while coefficients were being recomputed");

    // The configuration port never back-pressures.
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind lattice_flux_boundary_unknown lfb_chk u_lfb_chk (.*);

>>> tb/tb.sv
// Self-checking testbench for the D3Q7 flux boundary block, with its own fixed-point predictor.
module tb
    import lfb_pkg::*;
();

    localparam mode_t MODE_ADVC = 2'd0;
    localparam mode_t MODE_SPARE = 2'd3;
    localparam logic [CW-1:0] REG_NONE = 3'd7;
    localparam longint QMAX = 64'sd2147483647;
    localparam longint QMIN = -64'sd2147483648;
    localparam longint Q_ONE = 64'sd65536;
    localparam longint Q_HALF = 64'sd32768;
    localparam int DRAIN_CYCLES = 120;

    typedef struct {
        val_t udist;
        logic fault;
    } boundary_result_t;

    typedef struct {
        logic [8*VW-1:0] node;
        bit              typed;
        val_t            udist;
        logic            fault;
    } node_row_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            s_axis_tvalid = 1'b0;
    logic            s_axis_tready;
    logic [8*VW-1:0] s_axis_tdata = '0;
    logic            m_axis_tvalid;
    logic            m_axis_tready = 1'b0;
    logic [VW-1:0]   m_axis_tdata;
    logic            m_axis_tuser;
    logic            cfg_valid = 1'b0;
    logic            cfg_ready;
    logic [CW-1:0]   cfg_index = '0;
    logic [VW-1:0]   cfg_data = '0;

    boundary_result_t pending_results[$];
    int errors = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;

    // Local copy of the boundary configuration.
    mode_t  bc_mode;
    logic   bc_side;
    longint bc_tau, bc_flux, bc_diff, bc_val, bc_vt;

    lattice_flux_boundary_unknown uut (.*);

    always #5 clk = ~clk;

    function automatic longint unsigned qmag(longint v);
        return v < 0 ? longint'(-v) : longint'(v);
    endfunction

    function automatic longint qpack(bit neg, longint unsigned m);
        if (!neg)
            return m > longint'(QMAX) ? QMAX : longint'(m);
        if (m > longint'(QMAX) + 1)
            return QMIN;
        return -longint'(m);
    endfunction

    function automatic longint qadd(longint a, longint b);
        longint s;
        s = a + b;
        return s > QMAX ? QMAX : (s < QMIN ? QMIN : s);
    endfunction

    function automatic longint qsub(longint a, longint b);
        return qadd(a, b == QMIN ? QMAX : -b);
    endfunction

    function automatic longint qmul(longint a, longint b, int sh);
        longint unsigned p;
        p = qmag(a) * qmag(b);
        if (sh > 0)
            p = (p + (64'd1 << (sh - 1))) >> sh;
        return qpack((a < 0) != (b < 0), p);
    endfunction

    function automatic longint qdiv(longint n, longint d, inout bit fault);
        longint unsigned x, q, r, dd;
        if (d == 0) begin
            fault = 1'b1;
            return n < 0 ? QMIN : QMAX;
        end
        dd = qmag(d);
        x = qmag(n) << FB;
        q = x / dd;
        r = x % dd;
        if (r >= dd - r)
            q++;
        return qpack((n < 0) != (d < 0), q);
    endfunction

    function automatic boundary_result_t solve_unknown_dist(logic [8*VW-1:0] node);
        longint f[6];
        longint uz, ez, s, h, a, num, res, m, inner, d2, w, ws, den, t;
        bit fault;
        boundary_result_t o;
        fault = 1'b0;
        for (int i = 0; i < 6; i++)
            f[i] = longint'(val_t'(node[VW*i +: VW]));
        uz = longint'(val_t'(node[VW*6 +: VW]));
        ez = longint'(val_t'(node[VW*7 +: VW]));
        s = f[0];
        for (int i = 1; i < 6; i++)
            s = qadd(s, f[i]);
        h = qdiv(Q_HALF, bc_tau, fault);
        a = qsub(Q_ONE, h);
        if (bc_mode == MODE_DIFF) begin
            m = qmul(uz, s, FB);
            inner = bc_side ? qsub(f[5], m) : qadd(f[5], m);
            d2 = bc_side ? qadd(Q_ONE, uz) : qsub(Q_ONE, uz);
            num = qadd(bc_flux, qmul(a, inner, FB));
            res = qdiv(qdiv(num, a, fault), d2, fault);
        end
        else begin
            w = qmul(uz, h, FB);
            if (bc_mode == MODE_ELEC) begin
                t = qdiv(qmul(bc_diff, bc_val, 0), bc_vt, fault);
                w = qadd(w, qmul(t, ez, FB));
            end
            ws = qmul(w, s, FB);
            num = qadd(bc_flux, qmul(a, f[5], FB));
            num = bc_side ? qadd(num, ws) : qsub(num, ws);
            den = bc_side ? qsub(a, w) : qadd(a, w);
            res = qdiv(num, den, fault);
        end
        if (fault)
            res = num < 0 ? QMIN : QMAX;
        o.udist = val_t'(res);
        o.fault = fault;
        return o;
    endfunction

    function automatic logic [8*VW-1:0] node_bits(val_t f0, val_t f1, val_t f2, val_t f3,
                                                   val_t f4, val_t k, val_t uz, val_t ez);
        return {ez, uz, k, f4, f3, f2, f1, f0};
    endfunction

    function automatic val_t rand_value();
        int pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return VMAX;
        if (pick < 8)
            return VMIN;
        if (pick < 20)
            return val_t'($urandom);
        return val_t'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
    endfunction

    function automatic val_t rand_velocity();
        int pick;
        pick = $urandom_range(99);
        if (pick < 5)
            return val_t'($urandom);
        if (pick < 10)
            return $urandom_range(1) ? ONE : -ONE;
        return val_t'($signed($urandom_range(0, 98304)) - 49152);
    endfunction

    // Register write without lowering valid; the caller closes the burst.
    task automatic write_reg(logic [CW-1:0] idx, logic [VW-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            REG_MODE: bc_mode = mode_t'(data[1:0]);
            REG_SIDE: bc_side = data[0];
            REG_TAU:  bc_tau = longint'(data[VW-2:0]);
            REG_FLUX: bc_flux = longint'(val_t'(data));
            REG_DIFF: bc_diff = longint'(data[VW-2:0]);
            REG_VAL:  bc_val = longint'($signed(data[ZW-1:0]));
            REG_VT:   bc_vt = longint'(data[VW-2:0]);
            default: ;
        endcase
    endtask

    task automatic send_node(logic [8*VW-1:0] node, bit typed, val_t udist, logic fault);
        boundary_result_t r;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= node;
        do @(posedge clk); while (!s_axis_tready);
        if (typed) begin
            r.udist = udist;
            r.fault = fault;
        end
        else
            r = solve_unknown_dist(node);
        pending_results.push_back(r);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    always @(posedge clk) begin
        boundary_result_t e;
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result dist=%h fault=%b", $time, m_axis_tdata,
                         m_axis_tuser);
                errors++;
            end
            else begin
                e = pending_results.pop_front();
                if (m_axis_tdata !== e.udist) begin
                    $display("%0t: unknown_dist expected %h actual %h", $time, e.udist,
                             m_axis_tdata);
                    errors++;
                end
                if (m_axis_tuser !== e.fault) begin
                    $display("%0t: divide_fault expected %b actual %b", $time, e.fault,
                             m_axis_tuser);
                    errors++;
                end
            end
        end
    end

    initial begin
        #20000000;
        $display("tb: errors");
        $finish;
    end

    initial begin
        node_row_t rows[$];
        mode_t modes[4];
        logic [VW-1:0] v;
        int waited;
        modes = '{MODE_ADVC, MODE_DIFF, MODE_ELEC, MODE_SPARE};
        bc_mode = MODE_ADVC;
        bc_side = 1'b0;
        bc_tau = Q_ONE;
        bc_flux = 0;
        bc_diff = 0;
        bc_val = 1;
        bc_vt = Q_ONE;

        // With reset values h and a are both one half.
        rows.push_back('{node_bits(0, 0, 0, 0, 0, 0, 0, 0), 1, 0, 0});
        rows.push_back('{node_bits(0, 0, 0, 0, 0, ONE, 0, 0), 1, ONE, 0});
        rows.push_back('{node_bits(0, 0, 0, 0, 0, ONE, -HALF, 0), 1, 3 * ONE, 0});
        rows.push_back('{node_bits(0, 0, 0, 0, 0, 0, -ONE, 0), 1, VMAX, 1});
        rows.push_back('{node_bits(0, 0, 0, 0, 0, -ONE, -ONE, 0), 1, VMIN, 1});
        rows.push_back('{node_bits(VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX, VMAX), 0, 0, 0});
        rows.push_back('{node_bits(VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN, VMIN), 0, 0, 0});
        rows.push_back('{node_bits(ONE, ONE, ONE, ONE, ONE, 2 * ONE, HALF / 2, 0), 0, 0, 0});
        rows.push_back('{node_bits(0, ONE, 0, ONE, 0, ONE, VMAX, VMAX), 0, 0, 0});
        rows.push_back('{node_bits(ONE, 0, ONE, 0, ONE, -ONE, VMIN, VMIN), 0, 0, 0});
        rows.push_back('{{8{32'h5555_5555}}, 0, 0, 0});
        rows.push_back('{{8{32'haaaa_aaaa}}, 0, 0, 0});

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int p = 0; p < 10; p++) begin
            tx_idle_pct = p < 3 ? 11 : (p < 6 ? 77 : 0);
            rx_idle_pct = p < 3 ? 77 : (p < 6 ? 11 : 0);
            if (p == 0) begin
                foreach (rows[i])
                    send_node(rows[i].node, rows[i].typed, rows[i].udist, rows[i].fault);
            end
            else begin
                write_reg(REG_MODE, VW'(modes[p == 9 ? 3 : p % 3]));
                write_reg(REG_SIDE, VW'((p >> 1) & 1));
                case (p)
                    1: v = 32769;
                    2: v = 32'h7fff_ffff;
                    4: v = 0;
                    default: v = $urandom_range(32769, 4 * 65536);
                endcase
                write_reg(REG_TAU, v);
                v = p == 2 ? VMAX : (p == 5 ? VMIN
                    : VW'($signed($urandom_range(0, 4 * 65536)) - 2 * 65536));
                write_reg(REG_FLUX, v);
                write_reg(REG_DIFF, p == 6 ? 32'h7fff_ffff : VW'($urandom_range(0, 2 * 65536)));
                v = p == 8 ? VW'(5'b10000) : (p == 9 ? VW'(5'b01111)
                    : VW'($signed($urandom_range(0, 16)) - 8));
                write_reg(REG_VAL, v);
                v = p == 7 ? 0 : (p == 6 ? 1 : VW'($urandom_range(16384, 4 * 65536)));
                write_reg(REG_VT, v);
                write_reg(REG_NONE, $urandom);
                cfg_valid <= 1'b0;
            end
            for (int n = 0; n < 45; n++) begin
                if (p == 3 && n == 20) begin
                    s_axis_tvalid <= 1'b0;
                    wait_drained();
                end
                send_node(node_bits(rand_value(), rand_value(), rand_value(), rand_value(),
                                    rand_value(), rand_value(), rand_velocity(),
                                    rand_velocity()), 0, 0, 0);
            end
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end

        waited = 0;
        while (pending_results.size() != 0 && waited < 100000) begin
            @(posedge clk);
            waited++;
        end
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

>>> filelist.f
src/lfb_pkg.sv
src/lfb_cfg.sv
src/lfb_front.sv
src/lfb_div.sv
src/lattice_flux_boundary_unknown.sv
src/lfb_chk.sv
tb/tb.sv
